// ===== rtl/modular_inverse_ext_euclid_core_defines.svh =====
// ----------------------------------------------------------------------------
// Modular inverse core assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH

// Same-cycle implication.
`define MODINV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MODINV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/modinv_pkg.sv =====
// ----------------------------------------------------------------------------
// Modular inverse package
// Operand width and stream bus widths shared by the modular inverse core.
// ----------------------------------------------------------------------------
package modinv_pkg;

  // Operand width (value, modulus and inverse).
  localparam int WIDTH = 31;
  // Signed Bezout coefficient width.
  localparam int COEF_W = WIDTH + 1;
  // Bit counter width for one restoring division.
  localparam int CNT_W = $clog2(WIDTH);
  // Stream data widths, rounded up to whole bytes.
  localparam int IN_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WIDTH + 7) / 8) * 8;

endpackage

// ===== rtl/modular_inverse_ext_euclid_core.sv =====
// ----------------------------------------------------------------------------
// Modular inverse core (extended Euclid)
// Computes the inverse of a value modulo m with a bit-serial shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one beat per problem: value a and modulus m.
//   Output stream m_axis returns one beat per problem: the inverse in 0..m-1
//   (zero when none exists) and a flag in tuser set when m is nonzero and gcd(a, m) = 1.
//   s_axis_tready is high only while the core is idle; one beat is worked on
//   at a time.
// Sequencing:
//   Each Euclid step runs one restoring division through a single shared
//   subtract/compare unit, one quotient bit per cycle, followed by an update
//   state. After the last step (zero remainder) the core normalizes the
//   coefficient and then presents the result. A problem takes k division
//   steps, with k at most about 1.44 * WIDTH + 2. A zero modulus skips the loop.
//   The next beat can be accepted in the same cycle that output valid rises.
// Stall and reset:
//   The result sits in an output register; a new beat may be accepted while it
//   waits. If the receiver still stalls when the next result is ready, the
//   core holds in its final state until the output register frees up.
//   Reset (rst_ni low) drops any work in flight and clears output valid.
// ----------------------------------------------------------------------------
`include "modular_inverse_ext_euclid_core_defines.svh"

module modular_inverse_ext_euclid_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [30:0] a_value, [61:31] modulus, upper bits pad
  input  logic [modinv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [30:0] inverse, upper bits zero
  output logic [modinv_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [0] exists
  output logic                             m_axis_tuser
);

  localparam int W = modinv_pkg::WIDTH;
  localparam int C = modinv_pkg::COEF_W;
  localparam int CW = modinv_pkg::CNT_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_NORM = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          out_valid_q, out_valid_d;

  logic [W-1:0]  rp_q, rp_d;
  logic [W-1:0]  rc_q, rc_d;
  logic [C-1:0]  cp_q, cp_d;
  logic [C-1:0]  cc_q, cc_d;
  logic [W-1:0]  m_q, m_d;
  logic [W-1:0]  div_num_q, div_num_d;
  logic [W-1:0]  div_rem_q, div_rem_d;
  logic [C-1:0]  prod_q, prod_d;
  logic [C-1:0]  t_q, t_d;
  logic          exists_q, exists_d;
  logic [W-1:0]  inv_q, inv_d;
  logic          user_q, user_d;

  logic [W-1:0]  in_a, in_m;
  logic          in_fire, out_free;
  logic [W:0]    r_sh, r_sub;
  logic          fits;
  logic [C-1:0]  t_red;

  assign in_a = s_axis_tdata[W-1:0];
  assign in_m = s_axis_tdata[2*W-1:W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // Shared divider datapath: shift in the next dividend bit, trial subtract.
  assign r_sh = {div_rem_q, div_num_q[W-1]};
  assign r_sub = r_sh - {1'b0, rc_q};
  assign fits = (r_sh >= {1'b0, rc_q});

  assign t_red = (t_q >= {1'b0, m_q}) ? (t_q - {1'b0, m_q}) : t_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    out_valid_d = out_valid_q;
    rp_d = rp_q;
    rc_d = rc_q;
    cp_d = cp_q;
    cc_d = cc_q;
    m_d = m_q;
    div_num_d = div_num_q;
    div_rem_d = div_rem_q;
    prod_d = prod_q;
    t_d = t_q;
    exists_d = exists_q;
    inv_d = inv_q;
    user_d = user_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rp_d = in_a;
          rc_d = in_m;
          cp_d = C'(1);
          cc_d = '0;
          m_d = in_m;
          div_num_d = in_a;
          div_rem_d = '0;
          prod_d = '0;
          cnt_d = CW'(W - 1);
          if (in_m == '0) begin
            exists_d = 1'b0;
            state_d = ST_FIN;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; fold it into q * coef by Horner's rule.
        div_rem_d = fits ? r_sub[W-1:0] : r_sh[W-1:0];
        div_num_d = {div_num_q[W-2:0], 1'b0};
        prod_d = {prod_q[C-2:0], 1'b0} + (fits ? cc_q : '0);
        if (cnt_q == '0) begin
          state_d = ST_UPD;
        end else begin
          cnt_d = cnt_q - CW'(1);
        end
      end
      ST_UPD: begin
        rp_d = rc_q;
        rc_d = div_rem_q;
        cp_d = cc_q;
        cc_d = cp_q - prod_q;
        if (div_rem_q == '0) begin
          state_d = ST_NORM;
        end else begin
          div_num_d = rc_q;
          div_rem_d = '0;
          prod_d = '0;
          cnt_d = CW'(W - 1);
          state_d = ST_DIV;
        end
      end
      ST_NORM: begin
        exists_d = (rp_q == W'(1));
        t_d = cp_q[C-1] ? (cp_q + {1'b0, m_q}) : cp_q;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        // Hold here while the previous result is still stalled.
        if (out_free) begin
          inv_d = exists_q ? t_red[W-1:0] : '0;
          user_d = exists_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q <= rp_d;
    rc_q <= rc_d;
    cp_q <= cp_d;
    cc_q <= cc_d;
    m_q <= m_d;
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    prod_q <= prod_d;
    t_q <= t_d;
    exists_q <= exists_d;
    inv_q <= inv_d;
    user_q <= user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = modinv_pkg::OUT_DATA_W'(inv_q);
  assign m_axis_tuser = user_q;

  `MODINV_ASSERT_NEXT(a_accept_starts, in_fire,
    (state_q == ST_DIV) || (state_q == ST_FIN), "accepted beat did not start work")
  `MODINV_ASSERT_NOW(a_div_rem_below, state_q == ST_DIV,
    (rc_q != '0) && (div_rem_q < rc_q), "partial remainder not below divisor")
  `MODINV_ASSERT_NOW(a_norm_done, state_q == ST_NORM,
    rc_q == '0, "normalize entered with nonzero remainder")
  `MODINV_ASSERT_NEXT(a_fin_emits, (state_q == ST_FIN) && out_free,
    m_axis_tvalid && (state_q == ST_IDLE), "finished result not presented")

endmodule

// ===== test/modular_inverse_ext_euclid_core_test.sv =====
// ----------------------------------------------------------------------------
// Modular inverse core testbench
// Sends value/modulus beats into the core and checks each returned inverse and
// exists flag against a behavioral extended Euclid computed here. A directed
// batch of corner cases comes first. Random batches follow, with sender idle
// and receiver stall patterns varied from batch to batch.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WIDTH        = modinv_pkg::WIDTH;
  localparam int          IN_DATA_W    = modinv_pkg::IN_DATA_W;
  localparam int          OUT_DATA_W   = modinv_pkg::OUT_DATA_W;
  localparam int          CYCLE_LIMIT  = 4_000_000;
  localparam int          DRAIN_CYCLES = 1600;
  localparam logic [WIDTH-1:0] MAX_VAL = {WIDTH{1'b1}};

  typedef struct packed {
    logic [WIDTH-1:0] inverse;
    logic             exists;
  } answer_t;

  class inverse_ledger;
    answer_t pending_answers[$];
    int      err_count;

    function new();
      err_count = 0;
    endfunction

    // Extended Euclid on the value/modulus pair, inverse folded into 0..m-1.
    function answer_t solve_inverse(logic [WIDTH-1:0] a, logic [WIDTH-1:0] m);
      longint  r_old, r_now, r_nxt, quo, c_old, c_now, c_nxt, mm, rem;
      answer_t ans;
      ans = '0;
      mm  = longint'(m);
      if (mm != 0) begin
        r_old = longint'(a);
        r_now = mm;
        c_old = 1;
        c_now = 0;
        while (r_now != 0) begin
          quo   = r_old / r_now;
          r_nxt = r_old - quo * r_now;
          c_nxt = c_old - quo * c_now;
          r_old = r_now;
          r_now = r_nxt;
          c_old = c_now;
          c_now = c_nxt;
        end
        if (r_old == 1) begin
          ans.exists = 1'b1;
          if (c_old < 0) begin
            rem = (-c_old) % mm;
            ans.inverse = WIDTH'((rem == 0) ? 0 : mm - rem);
          end else begin
            ans.inverse = WIDTH'(c_old % mm);
          end
        end
      end
      return ans;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      err_count++;
    endtask

    function void note_problem(logic [WIDTH-1:0] a, logic [WIDTH-1:0] m);
      pending_answers.push_back(solve_inverse(a, m));
    endfunction

    task check_answer(logic [OUT_DATA_W-1:0] data, logic flag);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h exists=%b", data, flag));
      end else begin
        want = pending_answers.pop_front();
        if (data !== OUT_DATA_W'(want.inverse))
          report_mismatch($sformatf("inverse got %h want %h", data, want.inverse));
        if (flag !== want.exists)
          report_mismatch($sformatf("exists got %b want %b", flag, want.exists));
      end
    endtask

    function int pending();
      return pending_answers.size();
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  inverse_ledger    ledger = new();
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               cycle_count = 0;
  logic [WIDTH-1:0] fib_seq [0:46];

  modular_inverse_ext_euclid_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [30:0] a_value, [61:31] modulus, pad
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [30:0] inverse, pad
    .m_axis_tuser  (m_axis_tuser)    // [0] exists
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ledger.check_answer(m_axis_tdata, m_axis_tuser);
  end

  // Hold valid across back-to-back beats; drop it only for idle cycles.
  task automatic send_problem(logic [WIDTH-1:0] a, logic [WIDTH-1:0] m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - 2 * WIDTH){1'b0}}, m, a};
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_problem(a, m);
  endtask

  task automatic send_random_problem();
    int               kind;
    int               idx;
    longint           factor;
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] m;
    kind = $urandom_range(0, 99);
    a = WIDTH'($urandom());
    m = WIDTH'($urandom());
    if (kind < 20) begin
      // small modulus, value often far above it
      m = WIDTH'($urandom_range(1, 255));
      if ($urandom_range(0, 1) == 0) a = WIDTH'($urandom_range(0, 300));
    end else if (kind < 32) begin
      factor = longint'($urandom_range(2, 1000));
      a = WIDTH'(factor * longint'($urandom_range(0, 2_000_000)));
      m = WIDTH'(factor * longint'($urandom_range(1, 2_000_000)));
    end else if (kind < 42) begin
      // consecutive Fibonacci numbers drive the longest division chains
      idx = $urandom_range(20, 45);
      a = fib_seq[idx];
      m = fib_seq[idx + 1];
      if ($urandom_range(0, 1) == 0) begin
        a = fib_seq[idx + 1];
        m = fib_seq[idx];
      end
    end else if (kind < 52) begin
      case ($urandom_range(0, 6))
        0: m = WIDTH'(1);
        1: begin a = '0; if (m == '0) m = WIDTH'(2); end
        2: m = '0;
        3: a = m;
        4: a = m - 1'b1;
        5: a = WIDTH'(1);
        default: a = MAX_VAL;
      endcase
    end
    send_problem(a, m);
  endtask

  task automatic run_batch(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_problem();
  endtask

  initial begin
    fib_seq[0] = '0;
    fib_seq[1] = WIDTH'(1);
    for (int i = 2; i <= 46; i++) fib_seq[i] = fib_seq[i - 1] + fib_seq[i - 2];

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // modulus one, zero value, zero modulus, extremes, shared factors
    send_problem(0, 1);
    send_problem(5, 1);
    send_problem(MAX_VAL, 1);
    send_problem(0, 7);
    send_problem(0, MAX_VAL);
    send_problem(3, 0);
    send_problem(MAX_VAL, 0);
    send_problem(0, 0);
    send_problem(3, 7);
    send_problem(10, 7);
    send_problem(7, 7);
    send_problem(6, 7);
    send_problem(1, 2);
    send_problem(1, MAX_VAL);
    send_problem(MAX_VAL - 1'b1, MAX_VAL);
    send_problem(MAX_VAL, MAX_VAL - 1'b1);
    send_problem(MAX_VAL, MAX_VAL);
    send_problem(2, 4);
    send_problem(12, 18);
    send_problem(31'h4000_0000, MAX_VAL);
    send_problem(fib_seq[45], fib_seq[46]);
    send_problem(fib_seq[46], fib_seq[45]);

    run_batch(140, 0, 0);
    run_batch(135, 77, 0);
    run_batch(135, 0, 77);
    run_batch(140, 17, 17);

    s_axis_tvalid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (ledger.err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
